>>> design/spq_pkg.sv
// Shared types and constants for the stable priority queue with memory accounting.
// Used by spq_store and stable_priority_queue_with_memory; depends on nothing else.
package spq_pkg;

    // Number of entry slots in the queue (valid range 2 to 31).
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int PID_W   = 16;
    localparam int PRI_W   = 8;
    localparam int MEM_W   = 16;
    localparam int QCNT_W  = 5;

    localparam logic [MEM_W-1:0] MEMORY_TOTAL_RESET = 16'd4096;

    // Request kinds.
    localparam logic [1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [1:0] KIND_DEQUEUE = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [PRI_W-1:0] prio;
        logic [MEM_W-1:0] memory;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } store_wr_t;

endpackage

>>> design/stable_priority_queue_with_memory.sv
// Top level of the stable priority queue with a free-memory count.
// Depends on spq_pkg and instantiates spq_store for the entry slots.
//
// Usage:
// The input channel (s_valid/s_ready) carries one request per beat: enqueue,
// dequeue of the front entry, or remove by id. Every request produces exactly
// one result beat on the output channel (m_valid/m_ready) holding a status,
// the entry taken out (zero otherwise), the free memory count and the number
// of entries held after the request.
// Entries live in a store with one write port and one registered read port and
// are walked one slot per cycle by a small sequencer, so the block takes one
// request at a time. A refused request, a dequeue or remove on an empty queue
// and the unused kind go from CMD straight to FINISH; an enqueue first walks
// SHIFT_UP over the entries moved behind the new one, and a dequeue or remove
// walks SCAN over every entry held.
// s_ready returns in the same cycle as the result is registered. A new
// request may be accepted while the previous result still waits on a stalled
// receiver; its result then holds back until the output register frees up.
// Synchronous active-low reset empties the queue and loads the free count
// with 4096. A write on cfg_wr_en reloads the free count with cfg_wr_data and
// keeps the held entries; it is only to be issued by the user while the block
// is idle, and the block itself does not enforce this.
module stable_priority_queue_with_memory (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_item_pid,
    input  logic [7:0]  s_item_priority,
    input  logic [15:0] s_item_memory,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_out_pid,
    output logic [7:0]  m_out_priority,
    output logic [15:0] m_out_memory,
    output logic [15:0] m_free_memory_now,
    output logic [4:0]  m_queue_count,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int AddrW = spq_pkg::ADDR_W;
    localparam int CntW  = spq_pkg::CNT_W;
    localparam int MemW  = spq_pkg::MEM_W;
    localparam int QcW   = spq_pkg::QCNT_W;

    // IDLE waits for a request, CMD decodes it and issues the first store read,
    // SHIFT_UP walks from the back making room for an enqueue, SCAN walks from
    // the front to find and close up a removed entry, FINISH hands the result
    // to the output register.
    typedef enum logic [2:0] {
        IDLE,
        CMD,
        SHIFT_UP,
        SCAN,
        FINISH
    } state_t;

    state_t state_reg, state_next;

    // Latched request.
    logic [1:0]              kind_reg, kind_next;
    spq_pkg::entry_t         req_reg, req_next;

    // Walk position: in SHIFT_UP the slot being filled, in SCAN the slot whose
    // data is on the store read port this cycle.
    logic [CntW-1:0]         idx_reg, idx_next;
    logic                    found_reg, found_next;
    spq_pkg::entry_t         take_reg, take_next;
    logic [1:0]              stat_reg, stat_next;

    logic [CntW-1:0]         count_reg, count_next;
    logic [MemW-1:0]         free_reg, free_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_status_reg, m_status_next;
    spq_pkg::entry_t         m_entry_reg, m_entry_next;
    logic [MemW-1:0]         m_free_reg, m_free_next;
    logic [CntW-1:0]         m_count_reg, m_count_next;

    // Store ports.
    spq_pkg::store_wr_t      st_wr;
    logic [AddrW-1:0]        st_rd_addr;
    spq_pkg::entry_t         st_rd_data;

    logic [MemW:0]           give_sum;

    spq_store u_store (
        .aclk    (aclk),
        .wr      (st_wr),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // Memory returned by a removed entry, saturated at the top of the field.
    assign give_sum = {1'b0, free_reg} + {1'b0, take_reg.memory};

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        take_next     = take_reg;
        stat_next     = stat_reg;
        count_next    = count_reg;
        free_next     = free_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_entry_next  = m_entry_reg;
        m_free_next   = m_free_reg;
        m_count_next  = m_count_reg;
        st_wr         = '0;
        st_rd_addr    = '0;

        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    kind_next       = s_kind;
                    req_next.pid    = s_item_pid;
                    req_next.prio   = s_item_priority;
                    req_next.memory = s_item_memory;
                    state_next      = CMD;
                end
            end

            CMD: begin
                found_next = 1'b0;
                take_next  = '0;
                stat_next  = spq_pkg::ST_DONE;
                unique case (kind_reg) inside
                    spq_pkg::KIND_ENQUEUE: begin
                        if (count_reg == CntW'(spq_pkg::QUEUE_DEPTH)) begin
                            stat_next  = spq_pkg::ST_FULL;
                            state_next = FINISH;
                        end else if (req_reg.memory > free_reg) begin
                            stat_next  = spq_pkg::ST_NOMEM;
                            state_next = FINISH;
                        end else begin
                            // Start at the back; read the last held entry.
                            idx_next   = count_reg;
                            st_rd_addr = AddrW'(count_reg - 1'b1);
                            state_next = SHIFT_UP;
                        end
                    end
                    spq_pkg::KIND_DEQUEUE, spq_pkg::KIND_REMOVE: begin
                        if (count_reg == '0) begin
                            stat_next  = spq_pkg::ST_MISSING;
                            state_next = FINISH;
                        end else begin
                            idx_next   = '0;
                            st_rd_addr = '0;
                            state_next = SCAN;
                        end
                    end
                    default: begin
                        state_next = FINISH;
                    end
                endcase
            end

            SHIFT_UP: begin
                st_wr.en   = 1'b1;
                st_wr.addr = AddrW'(idx_reg);
                if (idx_reg == '0 || st_rd_data.prio <= req_reg.prio) begin
                    // Equal priorities stay ahead, so arrival order is kept.
                    st_wr.data = req_reg;
                    count_next = count_reg + 1'b1;
                    free_next  = free_reg - req_reg.memory;
                    state_next = FINISH;
                end else begin
                    st_wr.data = st_rd_data;
                    idx_next   = idx_reg - 1'b1;
                    st_rd_addr = AddrW'(idx_reg - CntW'(2));
                end
            end

            SCAN: begin
                if (idx_reg == count_reg) begin
                    if (found_reg) begin
                        count_next = count_reg - 1'b1;
                        free_next  = give_sum[MemW] ? {MemW{1'b1}} : give_sum[MemW-1:0];
                        stat_next  = spq_pkg::ST_DONE;
                    end else begin
                        stat_next  = spq_pkg::ST_MISSING;
                    end
                    state_next = FINISH;
                end else begin
                    if (found_reg) begin
                        // Close the gap: move this entry one slot toward the front.
                        st_wr.en   = 1'b1;
                        st_wr.addr = AddrW'(idx_reg - 1'b1);
                        st_wr.data = st_rd_data;
                    end else if (kind_reg == spq_pkg::KIND_DEQUEUE ||
                                 st_rd_data.pid == req_reg.pid) begin
                        found_next = 1'b1;
                        take_next  = st_rd_data;
                    end
                    idx_next   = idx_reg + 1'b1;
                    st_rd_addr = AddrW'(idx_reg + 1'b1);
                end
            end

            FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = stat_reg;
                    m_entry_next  = take_reg;
                    m_free_next   = free_reg;
                    m_count_next  = count_reg;
                    state_next    = IDLE;
                end
            end

            default: begin
                state_next = IDLE;
            end
        endcase

        // A register write reloads the free count; it is to come only while idle, not enforced here.
        if (cfg_wr_en) begin
            free_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            free_reg    <= spq_pkg::MEMORY_TOTAL_RESET;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
        end
        kind_reg     <= kind_next;
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        take_reg     <= take_next;
        stat_reg     <= stat_next;
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
        m_free_reg   <= m_free_next;
        m_count_reg  <= m_count_next;
    end

    // No request is taken while reset is held.
    assign s_ready           = (state_reg == IDLE) && aresetn;
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_out_pid         = m_entry_reg.pid;
    assign m_out_priority    = m_entry_reg.prio;
    assign m_out_memory      = m_entry_reg.memory;
    assign m_free_memory_now = m_free_reg;
    assign m_queue_count     = QcW'(m_count_reg);

endmodule

>>> design/spq_store.sv
// Entry store of the priority queue: one write port and one registered read port.
// Depends on spq_pkg for the entry type and the queue depth.
module spq_store (
    input  logic                        aclk,
    input  spq_pkg::store_wr_t          wr,
    input  logic [spq_pkg::ADDR_W-1:0]  rd_addr,
    output spq_pkg::entry_t             rd_data
);

    spq_pkg::entry_t mem_reg [spq_pkg::QUEUE_DEPTH];
    spq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/stable_priority_queue_with_memory_tb.sv
// Self-checking testbench for stable_priority_queue_with_memory: a directed script,
// then random request phases under several memory totals, with random stalls on both sides.
// Depends on spq_pkg and the RTL top level, which in turn needs spq_store.
`timescale 1ns / 1ps

module stable_priority_queue_with_memory_tb;

    // The fourth request kind has no meaning; the block must answer it and change nothing.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int FREE_CEILING = 65535;
    localparam int PHASES = 6;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [15:0] mem;
        logic [15:0] free_now;
        logic [4:0]  count;
    } result_beat_t;

    // One line of the directed script. Lines marked typed carry a hand-written
    // answer; the rest are answered by the scheduler model below.
    typedef struct packed {
        logic         typed;
        logic [1:0]   kind;
        logic [15:0]  pid;
        logic [7:0]   prio;
        logic [15:0]  mem;
        result_beat_t want;
    } script_line_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [15:0] s_item_pid;
    logic [7:0]  s_item_priority;
    logic [15:0] s_item_memory;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_out_pid;
    logic [7:0]  m_out_priority;
    logic [15:0] m_out_memory;
    logic [15:0] m_free_memory_now;
    logic [4:0]  m_queue_count;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    // Scheduler model: the held entries in service order, front at slot 0,
    // plus the free memory count kept wide enough to see saturation.
    logic [15:0] held_pid  [spq_pkg::QUEUE_DEPTH];
    logic [7:0]  held_prio [spq_pkg::QUEUE_DEPTH];
    logic [15:0] held_mem  [spq_pkg::QUEUE_DEPTH];
    int          held_n;
    int          free_units;

    // Result beats owed by the block, oldest first.
    result_beat_t due_results[$];
    script_line_t script[$];

    int failures;
    int send_steady;
    int recv_steady;

    int phase_total[PHASES];
    int phase_enq_pct[PHASES];
    int phase_mem_max[PHASES];
    int phase_items[PHASES];

    stable_priority_queue_with_memory uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_item_pid        (s_item_pid),
        .s_item_priority   (s_item_priority),
        .s_item_memory     (s_item_memory),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_out_pid         (m_out_pid),
        .m_out_priority    (m_out_priority),
        .m_out_memory      (m_out_memory),
        .m_free_memory_now (m_free_memory_now),
        .m_queue_count     (m_queue_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Takes the entry at pos out of the model, hands its memory back with
    // saturation at the top of the 16-bit range, and closes the gap.
    function automatic void release_slot(input int pos, inout result_beat_t r);
        r.pid  = held_pid[pos];
        r.prio = held_prio[pos];
        r.mem  = held_mem[pos];
        free_units = free_units + int'(held_mem[pos]);
        if (free_units > FREE_CEILING) begin
            free_units = FREE_CEILING;
        end
        for (int i = pos; i + 1 < held_n; i++) begin
            held_pid[i]  = held_pid[i + 1];
            held_prio[i] = held_prio[i + 1];
            held_mem[i]  = held_mem[i + 1];
        end
        held_n--;
    endfunction

    // Applies one request to the model and returns the beat it must produce.
    function automatic result_beat_t apply_request(input logic [1:0] kind,
                                                   input logic [15:0] pid,
                                                   input logic [7:0] prio,
                                                   input logic [15:0] mem);
        result_beat_t r;
        int pos;
        r = '0;
        r.status = spq_pkg::ST_DONE;
        case (kind)
            spq_pkg::KIND_ENQUEUE: begin
                // A full queue wins over a memory shortage.
                if (held_n >= spq_pkg::QUEUE_DEPTH) begin
                    r.status = spq_pkg::ST_FULL;
                end else if (int'(mem) > free_units) begin
                    r.status = spq_pkg::ST_NOMEM;
                end else begin
                    // Insert behind every entry of equal or better priority,
                    // which keeps arrival order among equals.
                    pos = 0;
                    while (pos < held_n && held_prio[pos] <= prio) pos++;
                    for (int i = held_n; i > pos; i--) begin
                        held_pid[i]  = held_pid[i - 1];
                        held_prio[i] = held_prio[i - 1];
                        held_mem[i]  = held_mem[i - 1];
                    end
                    held_pid[pos]  = pid;
                    held_prio[pos] = prio;
                    held_mem[pos]  = mem;
                    held_n++;
                    free_units = free_units - int'(mem);
                end
            end
            spq_pkg::KIND_DEQUEUE: begin
                if (held_n == 0) begin
                    r.status = spq_pkg::ST_MISSING;
                end else begin
                    release_slot(0, r);
                end
            end
            spq_pkg::KIND_REMOVE: begin
                // With duplicate ids the one nearest the front goes.
                pos = 0;
                while (pos < held_n && held_pid[pos] != pid) pos++;
                if (pos >= held_n) begin
                    r.status = spq_pkg::ST_MISSING;
                end else begin
                    release_slot(pos, r);
                end
            end
            default: begin
            end
        endcase
        r.free_now = free_units[15:0];
        r.count    = held_n[4:0];
        return r;
    endfunction

    function automatic void add_line(input logic typed, input logic [1:0] kind,
                                     input logic [15:0] pid, input logic [7:0] prio,
                                     input logic [15:0] mem, input logic [1:0] st,
                                     input logic [15:0] opid, input logic [7:0] oprio,
                                     input logic [15:0] omem, input logic [15:0] ofree,
                                     input logic [4:0] ocount);
        script_line_t line;
        line.typed = typed;
        line.kind  = kind;
        line.pid   = pid;
        line.prio  = prio;
        line.mem   = mem;
        line.want  = '{st, opid, oprio, omem, ofree, ocount};
        script.push_back(line);
    endfunction

    // Idle lengths: mostly none or short, a few long, and now and then a
    // run of back-to-back beats with no idling at all.
    function automatic int pick_gap(inout int steady);
        int r;
        if (steady > 0) begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            steady = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Drives one request beat, holds it until accepted and then records the
    // result it owes. Valid stays high on return so that a following beat
    // with no gap goes out on the very next edge.
    task automatic send_request(input logic [1:0] kind, input logic [15:0] pid,
                                input logic [7:0] prio, input logic [15:0] mem,
                                input logic typed, input result_beat_t typed_want);
        int gap;
        result_beat_t predicted;
        gap = pick_gap(send_steady);
        if (gap > 0) begin
            if (s_valid) begin
                s_valid <= 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_item_pid      <= pid;
        s_item_priority <= prio;
        s_item_memory   <= mem;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(kind, pid, prio, mem);
        due_results.push_back(typed ? typed_want : predicted);
    endtask

    // Stops sending and waits until every owed result beat has come back.
    task automatic wait_drained();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    // Reloads the free count; only done with nothing in flight. Every request
    // owes a result, so a drained queue means the block is idle, and an extra
    // wait lets its sequencer settle.
    task automatic load_memory_total(input logic [15:0] units);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_data <= units;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        free_units = int'(units);
    endtask

    // Random request shaped by the phase: how often to enqueue and how big
    // entries get. Ids come mostly from a small pool so that removes hit and
    // duplicates occur; removes usually name an id the queue really holds.
    task automatic make_request(input int enq_pct, input int mem_max,
                                output logic [1:0] kind, output logic [15:0] pid,
                                output logic [7:0] prio, output logic [15:0] mem);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct) begin
            kind = spq_pkg::KIND_ENQUEUE;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 40) kind = spq_pkg::KIND_DEQUEUE;
            else if (r < 92) kind = spq_pkg::KIND_REMOVE;
            else kind = KIND_UNUSED;
        end

        if (kind == spq_pkg::KIND_REMOVE && held_n > 0 && $urandom_range(0, 3) != 0) begin
            pid = held_pid[$urandom_range(0, held_n - 1)];
        end else if ($urandom_range(0, 3) == 0) begin
            pid = 16'($urandom);
        end else begin
            pid = 16'($urandom_range(0, 15));
        end

        r = $urandom_range(0, 99);
        if (r < 30) prio = 8'($urandom_range(0, 3));
        else if (r < 40) prio = 8'hFF;
        else prio = 8'($urandom);

        r = $urandom_range(0, 99);
        if (r < 10) mem = 16'h0000;
        else if (r < 15) mem = 16'hFFFF;
        else mem = 16'($urandom_range(0, mem_max));
    endtask

    // Result side: every accepted beat is matched against the oldest owed one.
    always @(posedge aclk) begin : result_check
        result_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing owed: status %0d pid 0x%0h", m_status,
                       m_out_pid);
                failures++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 16'(want.status), 16'(m_status));
                check_field("out_pid", want.pid, m_out_pid);
                check_field("out_priority", 16'(want.prio), 16'(m_out_priority));
                check_field("out_memory", want.mem, m_out_memory);
                check_field("free_memory_now", want.free_now, m_free_memory_now);
                check_field("queue_count", 16'(want.count), 16'(m_queue_count));
            end
        end
    end

    // Receiver: ready in bursts, broken by stalls of random length.
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            gap = pick_gap(recv_steady);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Hard stop, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("** stable_priority_queue_with_memory: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [15:0] mem;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = spq_pkg::KIND_ENQUEUE;
        s_item_pid      = '0;
        s_item_priority = '0;
        s_item_memory   = '0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        failures        = 0;
        send_steady     = 0;
        recv_steady     = 0;
        held_n          = 0;
        free_units      = int'(spq_pkg::MEMORY_TOTAL_RESET);

        // Out of reset: empty queue, 4096 free. The first lines hit the empty
        // and missing cases, the unused kind, a size one above the free count,
        // a zero size, a size that takes every free unit, and the return of it.
        add_line(1, spq_pkg::KIND_DEQUEUE, 16'h0000, 8'd0, 16'd0, spq_pkg::ST_MISSING,
                 0, 0, 0, 4096, 0);
        add_line(1, spq_pkg::KIND_REMOVE, 16'h1234, 8'd0, 16'd0, spq_pkg::ST_MISSING,
                 0, 0, 0, 4096, 0);
        add_line(1, KIND_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, spq_pkg::ST_DONE,
                 0, 0, 0, 4096, 0);
        add_line(1, spq_pkg::KIND_ENQUEUE, 16'h0001, 8'd5, 16'd4097, spq_pkg::ST_NOMEM,
                 0, 0, 0, 4096, 0);
        add_line(1, spq_pkg::KIND_ENQUEUE, 16'hFFFF, 8'hFF, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 4096, 1);
        add_line(1, spq_pkg::KIND_ENQUEUE, 16'h0000, 8'd0, 16'd4096, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 2);
        add_line(1, spq_pkg::KIND_ENQUEUE, 16'h0002, 8'd0, 16'd1, spq_pkg::ST_NOMEM,
                 0, 0, 0, 0, 2);
        add_line(1, spq_pkg::KIND_DEQUEUE, 16'h0000, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 16'h0000, 8'd0, 16'd4096, 4096, 1);
        add_line(1, spq_pkg::KIND_DEQUEUE, 16'h0000, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 16'hFFFF, 8'hFF, 16'd0, 4096, 0);
        // Ties at one priority must come out in arrival order; id 11 is held
        // twice and a remove must take the copy nearer the front.
        add_line(0, spq_pkg::KIND_ENQUEUE, 16'd10, 8'd7, 16'd100, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_ENQUEUE, 16'd11, 8'd7, 16'd200, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_ENQUEUE, 16'd12, 8'd3, 16'd300, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_ENQUEUE, 16'd13, 8'd7, 16'd400, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_ENQUEUE, 16'd11, 8'd7, 16'd50, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_REMOVE, 16'd11, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_REMOVE, 16'd99, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_DEQUEUE, 16'd0, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_DEQUEUE, 16'd0, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_ENQUEUE, 16'hA5A5, 8'h5A, 16'h0F0F, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_REMOVE, 16'd13, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_REMOVE, 16'd11, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_REMOVE, 16'hA5A5, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);
        add_line(0, spq_pkg::KIND_DEQUEUE, 16'd0, 8'd0, 16'd0, spq_pkg::ST_DONE,
                 0, 0, 0, 0, 0);

        // Random phases. The totals include both extremes; a total of zero admits
        // only zero-size entries until held ones hand memory back, and raising the
        // total to the top while entries are still held makes returned memory saturate.
        phase_total   = '{65535, 0, 4096, 65535, 1, 32768};
        phase_enq_pct = '{75, 45, 60, 55, 50, 65};
        phase_mem_max = '{2000, 40, 1500, 65535, 2, 5000};
        phase_items   = '{170, 110, 150, 150, 110, 180};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[k]) begin
            send_request(script[k].kind, script[k].pid, script[k].prio, script[k].mem,
                         script[k].typed, script[k].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            load_memory_total(phase_total[ph][15:0]);
            repeat (phase_items[ph]) begin
                // Now and then hold off until the block has answered everything.
                if ($urandom_range(0, 99) < 3) begin
                    wait_drained();
                end
                make_request(phase_enq_pct[ph], phase_mem_max[ph], kind, pid, prio, mem);
                send_request(kind, pid, prio, mem, 1'b0, '0);
            end
        end

        wait_drained();
        // Room for any stray beat the block might still push out.
        repeat (40) @(posedge aclk);

        if (failures == 0 && due_results.size() == 0) begin
            $display("** stable_priority_queue_with_memory: PASSED **");
        end else begin
            $display("** stable_priority_queue_with_memory: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
design/spq_pkg.sv
design/spq_store.sv
design/stable_priority_queue_with_memory.sv
tb/stable_priority_queue_with_memory_tb.sv
